/* src/dcpc_pkg.sv */
package dcpc_pkg;

   // cells at or beyond this index are taken as empty scan positions
   localparam int unsigned DCPC_MAX_CELLS   = 32;
   localparam int unsigned DCPC_QUEUE_DEPTH = 4;

   localparam logic [7:0]  N_SIGMA_X_RESET  = 8'd48;
   localparam logic [7:0]  N_SIGMA_T_RESET  = 8'd48;
   localparam logic [7:0]  LAYER_GAP_RESET  = 8'd20;
   localparam logic [15:0] TIME_SLOPE_RESET = 16'd558;

   typedef enum logic [1:0] {
      CSR_N_SIGMA_X  = 2'd0,
      CSR_N_SIGMA_T  = 2'd1,
      CSR_LAYER_GAP  = 2'd2,
      CSR_TIME_SLOPE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  n_sigma_x;
      logic [7:0]  n_sigma_t;
      logic [7:0]  layer_gap;
      logic [15:0] time_slope;
   } cfg_type;

   // classified cell, with its own time offset and cut limits worked out
   typedef struct packed {
      logic        hit;
      logic        eog;
      logic [19:0] t;
      logic [15:0] q;
      logic [15:0] x;
      logic [15:0] y;
      logic        down;
      logic [2:0]  col;
      logic [4:0]  cell_no;
      logic [19:0] off_mag;
      logic [23:0] cut_x;
      logic [23:0] cut_t;
   } cell_word_type;

   typedef struct packed {
      logic        pair_kind;
      logic [19:0] out_time;
      logic [15:0] out_charge;
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic [7:0]  out_z;
      logic [2:0]  first_column;
      logic [4:0]  first_cell;
      logic [2:0]  second_column;
      logic [4:0]  second_cell;
      logic        last_of_run;
   } result_type;

endpackage

/* src/dcpc_if.sv */
interface dcpc_req_if;
   logic               valid;
   logic               ready;
   logic               hit_present;
   logic signed [19:0] hit_time;
   logic [15:0]        hit_charge;
   logic signed [15:0] hit_x;
   logic signed [15:0] hit_y;
   logic [15:0]        spread_x;
   logic [15:0]        spread_t;
   logic               downstream;
   logic [2:0]         column_id;
   logic [4:0]         cell_id;
   logic               end_of_group;

   modport source (
      output valid, hit_present, hit_time, hit_charge, hit_x, hit_y, spread_x, spread_t,
             downstream, column_id, cell_id, end_of_group,
      input  ready
   );
   modport sink (
      input  valid, hit_present, hit_time, hit_charge, hit_x, hit_y, spread_x, spread_t,
             downstream, column_id, cell_id, end_of_group,
      output ready
   );
endinterface

interface dcpc_rsp_if;
   logic               valid;
   logic               ready;
   logic               pair_kind;
   logic signed [19:0] out_time;
   logic [15:0]        out_charge;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [7:0]  out_z;
   logic [2:0]         first_column;
   logic [4:0]         first_cell;
   logic [2:0]         second_column;
   logic [4:0]         second_cell;
   logic               last_of_run;

   modport source (
      output valid, pair_kind, out_time, out_charge, out_x, out_y, out_z, first_column,
             first_cell, second_column, second_cell, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, pair_kind, out_time, out_charge, out_x, out_y, out_z, first_column,
             first_cell, second_column, second_cell, last_of_run,
      output ready
   );
endinterface

/* src/detector_cell_pair_clusterer_top.sv */
// Channel   Dir  Handshake          Word
// req_chan  in   valid/ready        one scanned cell
// rsp_chan  out  valid/ready        one cluster (single or pair)
// csr_*     in   csr_wr_en only     register index and data, no read-back
//
// One cell per cycle enters while neither side stalls; a cell causing two clusters gives two
// output words. Clusters a cell releases reach rsp_chan through the front register, the
// queue, then the output buffer; the output port moving one word a cycle while rsp_chan is
// ready sets the rate.
// Synchronous active-high reset clears the held cell, queue and buffers; registers
// take their defaults. Either side may stall; the queue absorbs front/back skew.
module detector_cell_pair_clusterer_top
   import dcpc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DCPC_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   dcpc_req_if.sink    req_chan,
   dcpc_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   cfg_type       cfg_ff, cfg_in;
   logic          f_valid;
   logic          f_ready;
   cell_word_type f_word;
   logic          b_valid;
   logic          b_ready;
   cell_word_type b_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_N_SIGMA_X:  cfg_in.n_sigma_x  = csr_wr_data[7:0];
            CSR_N_SIGMA_T:  cfg_in.n_sigma_t  = csr_wr_data[7:0];
            CSR_LAYER_GAP:  cfg_in.layer_gap  = csr_wr_data[7:0];
            CSR_TIME_SLOPE: cfg_in.time_slope = csr_wr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.n_sigma_x  <= N_SIGMA_X_RESET;
         cfg_ff.n_sigma_t  <= N_SIGMA_T_RESET;
         cfg_ff.layer_gap  <= LAYER_GAP_RESET;
         cfg_ff.time_slope <= TIME_SLOPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dcpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .word_valid (f_valid),
      .word_ready (f_ready),
      .word       (f_word)
   );

   dcpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_word   (f_word),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_word  (b_word)
   );

   dcpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .word_valid (b_valid),
      .word_ready (b_ready),
      .word       (b_word),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* src/dcpc_front.sv */
module dcpc_front
   import dcpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   dcpc_req_if.sink      req_chan,
   output logic          word_valid,
   input  logic          word_ready,
   output cell_word_type word
);

   logic          st_valid_ff, st_valid_in;
   cell_word_type st_word_ff, st_word_in;
   logic          accept;
   logic          push;
   logic [20:0]   t_ext;
   logic [20:0]   t_abs;
   logic [35:0]   off_prod;

   assign push           = st_valid_ff && word_ready;
   assign req_chan.ready = !st_valid_ff || word_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign t_ext    = {req_chan.hit_time[19], req_chan.hit_time};
   assign t_abs    = t_ext[20] ? (21'd0 - t_ext) : t_ext;
   assign off_prod = {16'd0, t_abs[19:0]} * {20'd0, cfg.time_slope};

   always_comb begin
      st_word_in.hit     = req_chan.hit_present
                           && ({4'd0, req_chan.cell_id} < 9'(DCPC_MAX_CELLS));
      st_word_in.eog     = req_chan.end_of_group;
      st_word_in.t       = req_chan.hit_time;
      st_word_in.q       = req_chan.hit_charge;
      st_word_in.x       = req_chan.hit_x;
      st_word_in.y       = req_chan.hit_y;
      st_word_in.down    = req_chan.downstream;
      st_word_in.col     = req_chan.column_id;
      st_word_in.cell_no = req_chan.cell_id;
      st_word_in.off_mag = off_prod[35:16];
      st_word_in.cut_x   = {8'd0, req_chan.spread_x} * {16'd0, cfg.n_sigma_x};
      st_word_in.cut_t   = {8'd0, req_chan.spread_t} * {16'd0, cfg.n_sigma_t};
   end

   always_comb begin
      st_valid_in = st_valid_ff;
      if (accept) begin
         st_valid_in = 1'b1;
      end else if (push) begin
         st_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_word_ff <= st_word_in;
      end
   end

   assign word_valid = st_valid_ff;
   assign word       = st_word_ff;

endmodule

/* src/dcpc_queue.sv */
module dcpc_queue
   import dcpc_pkg::*;
#(
   parameter int unsigned DEPTH = DCPC_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  cell_word_type in_word,
   output logic          out_valid,
   input  logic          out_ready,
   output cell_word_type out_word
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   cell_word_type         mem_ff [DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = (cnt_ff != CntW'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      cnt_in = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

/* src/dcpc_back.sv */
module dcpc_back
   import dcpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          word_valid,
   output logic          word_ready,
   input  cell_word_type word,
   dcpc_rsp_if.source    rsp_chan
);

   logic          held_valid_ff, held_valid_in;
   logic          held_consumed_ff, held_consumed_in;
   cell_word_type held_ff;

   result_type    slot0_ff, slot0_in;
   result_type    slot1_ff, slot1_in;
   logic [1:0]    rsp_cnt_ff, rsp_cnt_in;

   logic          drain;
   logic          pop;
   logic [1:0]    cnt_keep;
   logic [1:0]    n_new;
   result_type    keep0;
   result_type    res_a;
   result_type    res_b;
   result_type    new0;

   logic [16:0]   dx;
   logic [16:0]   adx;
   logic [20:0]   off_s;
   logic [22:0]   dt_base;
   logic [22:0]   dt;
   logic [22:0]   adt;
   logic          x_ok;
   logic          t_ok;
   logic          pairs;
   logic          res_a_ok;
   logic          res_b_ok;
   logic          swap;
   logic [20:0]   t_sum;
   logic [16:0]   q_sum;
   logic [16:0]   x_sum;
   logic [16:0]   y_sum;
   logic [7:0]    z_half;
   logic [7:0]    z_held;
   logic [7:0]    z_cur;

   // cuts against the held cell's spreads and layer-corrected time
   assign dx    = {held_ff.x[15], held_ff.x} - {word.x[15], word.x};
   assign adx   = dx[16] ? (17'd0 - dx) : dx;
   assign off_s = held_ff.t[19] ? (21'd0 - {1'b0, held_ff.off_mag}) : {1'b0, held_ff.off_mag};
   assign dt_base = word.down ? ({{3{held_ff.t[19]}}, held_ff.t} + {{2{off_s[20]}}, off_s})
                              : ({{3{held_ff.t[19]}}, held_ff.t} - {{2{off_s[20]}}, off_s});
   assign dt    = dt_base - {{3{word.t[19]}}, word.t};
   assign adt   = dt[22] ? (23'd0 - dt) : dt;
   assign x_ok  = {3'd0, adx, 4'd0} < held_ff.cut_x;
   assign t_ok  = {adt, 4'd0} < {3'd0, held_ff.cut_t};
   assign pairs = held_valid_ff && word.hit && x_ok && t_ok;

   assign res_a_ok = held_valid_ff && (pairs || !held_consumed_ff);
   assign res_b_ok = word.hit && word.eog && !pairs;

   assign t_sum  = {held_ff.t[19], held_ff.t} + {word.t[19], word.t};
   assign q_sum  = {1'b0, held_ff.q} + {1'b0, word.q};
   assign x_sum  = {held_ff.x[15], held_ff.x} + {word.x[15], word.x};
   assign y_sum  = {held_ff.y[15], held_ff.y} + {word.y[15], word.y};
   assign z_half = {1'b0, cfg.layer_gap[7:1]};
   assign z_held = held_ff.down ? (8'd0 - z_half) : z_half;
   assign z_cur  = word.down ? (8'd0 - z_half) : z_half;
   // upstream cell first, held cell first when both claim one layer
   assign swap   = held_ff.down && !word.down;

   always_comb begin
      res_a.last_of_run = !res_b_ok;
      if (pairs) begin
         res_a.pair_kind  = 1'b1;
         res_a.out_time   = t_sum[20:1];
         res_a.out_charge = q_sum[16:1];
         res_a.out_x      = x_sum[16:1];
         res_a.out_y      = y_sum[16:1];
         res_a.out_z      = 8'd0;
         if (swap) begin
            res_a.first_column  = word.col;
            res_a.first_cell    = word.cell_no;
            res_a.second_column = held_ff.col;
            res_a.second_cell   = held_ff.cell_no;
         end else begin
            res_a.first_column  = held_ff.col;
            res_a.first_cell    = held_ff.cell_no;
            res_a.second_column = word.col;
            res_a.second_cell   = word.cell_no;
         end
      end else begin
         res_a.pair_kind     = 1'b0;
         res_a.out_time      = held_ff.t;
         res_a.out_charge    = held_ff.q;
         res_a.out_x         = held_ff.x;
         res_a.out_y         = held_ff.y;
         res_a.out_z         = z_held;
         res_a.first_column  = held_ff.col;
         res_a.first_cell    = held_ff.cell_no;
         res_a.second_column = 3'd0;
         res_a.second_cell   = 5'd0;
      end
   end

   always_comb begin
      res_b.pair_kind     = 1'b0;
      res_b.out_time      = word.t;
      res_b.out_charge    = word.q;
      res_b.out_x         = word.x;
      res_b.out_y         = word.y;
      res_b.out_z         = z_cur;
      res_b.first_column  = word.col;
      res_b.first_cell    = word.cell_no;
      res_b.second_column = 3'd0;
      res_b.second_cell   = 5'd0;
      res_b.last_of_run   = 1'b1;
   end

   // two-slot output buffer, slot0 faces the port
   assign drain      = rsp_chan.valid && rsp_chan.ready;
   assign cnt_keep   = rsp_cnt_ff - {1'b0, drain};
   assign n_new      = {1'b0, res_a_ok} + {1'b0, res_b_ok};
   assign word_ready = ({1'b0, cnt_keep} + {1'b0, n_new}) <= 3'd2;
   assign pop        = word_valid && word_ready;
   assign keep0      = drain ? slot1_ff : slot0_ff;
   assign new0       = res_a_ok ? res_a : res_b;

   always_comb begin
      case (cnt_keep)
         2'd0: begin
            slot0_in = new0;
            slot1_in = res_b;
         end
         2'd1: begin
            slot0_in = keep0;
            slot1_in = new0;
         end
         default: begin
            slot0_in = slot0_ff;
            slot1_in = slot1_ff;
         end
      endcase
      rsp_cnt_in = cnt_keep + (pop ? n_new : 2'd0);
   end

   always_comb begin
      held_valid_in    = held_valid_ff;
      held_consumed_in = held_consumed_ff;
      if (pop) begin
         held_valid_in    = word.hit && !word.eog;
         held_consumed_in = word.hit && !word.eog && pairs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff    <= 1'b0;
         held_consumed_ff <= 1'b0;
         rsp_cnt_ff       <= 2'd0;
      end else begin
         held_valid_ff    <= held_valid_in;
         held_consumed_ff <= held_consumed_in;
         rsp_cnt_ff       <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (pop) begin
         held_ff <= word;
      end
   end

   assign rsp_chan.valid         = (rsp_cnt_ff != 2'd0);
   assign rsp_chan.pair_kind     = slot0_ff.pair_kind;
   assign rsp_chan.out_time      = slot0_ff.out_time;
   assign rsp_chan.out_charge    = slot0_ff.out_charge;
   assign rsp_chan.out_x         = slot0_ff.out_x;
   assign rsp_chan.out_y         = slot0_ff.out_y;
   assign rsp_chan.out_z         = slot0_ff.out_z;
   assign rsp_chan.first_column  = slot0_ff.first_column;
   assign rsp_chan.first_cell    = slot0_ff.first_cell;
   assign rsp_chan.second_column = slot0_ff.second_column;
   assign rsp_chan.second_cell   = slot0_ff.second_cell;
   assign rsp_chan.last_of_run   = slot0_ff.last_of_run;

`ifndef SYNTHESIS
   a_consumed_needs_held: assert property (@(posedge clock) disable iff (reset)
      held_consumed_ff |-> held_valid_ff)
      else $error("consumed flag set with no held cell");

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_cnt_ff != 2'd3)
      else $error("output buffer overfilled");

   a_double_shows: assert property (@(posedge clock) disable iff (reset)
      (pop && res_a_ok && res_b_ok) |=> (rsp_cnt_ff == 2'd2) && !rsp_chan.last_of_run)
      else $error("two-word run not buffered in order");

   a_single_second_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.pair_kind) |->
         (rsp_chan.second_column == 3'd0) && (rsp_chan.second_cell == 5'd0))
      else $error("single cluster carries a second cell");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
   import dcpc_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int TOTAL_CELLS   = 1550;

   typedef struct {
      logic        hit_present;
      logic [19:0] hit_time;
      logic [15:0] hit_charge;
      logic [15:0] hit_x;
      logic [15:0] hit_y;
      logic [15:0] spread_x;
      logic [15:0] spread_t;
      logic        downstream;
      logic [2:0]  column_id;
      logic [4:0]  cell_id;
      logic        end_of_group;
   } scan_cell_t;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   dcpc_req_if req_chan ();
   dcpc_rsp_if rsp_chan ();

   detector_cell_pair_clusterer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   cfg_type    cfg;
   bit         held_ok;
   bit         held_used;
   scan_cell_t held;
   result_type expected_clusters[$];

   int errors;
   int cells_sent;
   int clusters_seen;
   int pairs_seen;
   int settings_run;
   bit idle_on;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint sx20(logic [19:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint sx16(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic result_type make_cluster(bit kind, longint t, longint q, longint x,
                                               longint y, longint z, logic [2:0] c1,
                                               logic [4:0] e1, logic [2:0] c2,
                                               logic [4:0] e2);
      result_type r;
      r.pair_kind     = kind;
      r.out_time      = 20'(t);
      r.out_charge    = 16'(q);
      r.out_x         = 16'(x);
      r.out_y         = 16'(y);
      r.out_z         = 8'(z);
      r.first_column  = c1;
      r.first_cell    = e1;
      r.second_column = c2;
      r.second_cell   = e2;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   function automatic longint layer_z(logic down);
      longint h;
      h = longint'(cfg.layer_gap >> 1);
      return down ? -h : h;
   endfunction

   function automatic void predict_clusters(scan_cell_t c);
      result_type run[$];
      result_type r;
      bit     hit;
      bit     pairs;
      bit     cur_used;
      longint ht, ct, hx, cx, hy, cy, off, dt;
      hit      = c.hit_present && (c.cell_id < DCPC_MAX_CELLS);
      cur_used = 1'b0;
      ct = sx20(c.hit_time);
      cx = sx16(c.hit_x);
      cy = sx16(c.hit_y);
      if (held_ok) begin
         ht = sx20(held.hit_time);
         hx = sx16(held.hit_x);
         hy = sx16(held.hit_y);
         pairs = 1'b0;
         if (hit) begin
            off = (mag(ht) * longint'(cfg.time_slope)) / 65536;
            if (ht < 0) off = -off;
            // layer correction: sign follows the layer of the new cell
            dt = c.downstream ? ht + off - ct : ht - off - ct;
            pairs = (mag(hx - cx) * 16 < longint'(held.spread_x) * longint'(cfg.n_sigma_x)) &&
                    (mag(dt) * 16 < longint'(held.spread_t) * longint'(cfg.n_sigma_t));
         end
         if (pairs) begin
            if (held.downstream && !c.downstream)
               r = make_cluster(1, (ht + ct) >>> 1,
                                (longint'(held.hit_charge) + longint'(c.hit_charge)) >> 1,
                                (hx + cx) >>> 1, (hy + cy) >>> 1, 0,
                                c.column_id, c.cell_id, held.column_id, held.cell_id);
            else
               r = make_cluster(1, (ht + ct) >>> 1,
                                (longint'(held.hit_charge) + longint'(c.hit_charge)) >> 1,
                                (hx + cx) >>> 1, (hy + cy) >>> 1, 0,
                                held.column_id, held.cell_id, c.column_id, c.cell_id);
            run.push_back(r);
            cur_used = 1'b1;
         end else if (!held_used) begin
            run.push_back(make_cluster(0, ht, longint'(held.hit_charge), hx, hy,
                                       layer_z(held.downstream), held.column_id,
                                       held.cell_id, 3'd0, 5'd0));
         end
         held_ok   = 1'b0;
         held_used = 1'b0;
      end
      if (hit) begin
         if (c.end_of_group) begin
            if (!cur_used)
               run.push_back(make_cluster(0, ct, longint'(c.hit_charge), cx, cy,
                                          layer_z(c.downstream), c.column_id, c.cell_id,
                                          3'd0, 5'd0));
         end else begin
            held_ok   = 1'b1;
            held_used = cur_used;
            held      = c;
         end
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) expected_clusters.push_back(run[i]);
   endfunction

   task automatic compare_field(string name, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   task automatic check_cluster();
      result_type got;
      result_type want;
      got.pair_kind     = rsp_chan.pair_kind;
      got.out_time      = rsp_chan.out_time;
      got.out_charge    = rsp_chan.out_charge;
      got.out_x         = rsp_chan.out_x;
      got.out_y         = rsp_chan.out_y;
      got.out_z         = rsp_chan.out_z;
      got.first_column  = rsp_chan.first_column;
      got.first_cell    = rsp_chan.first_cell;
      got.second_column = rsp_chan.second_column;
      got.second_cell   = rsp_chan.second_cell;
      got.last_of_run   = rsp_chan.last_of_run;
      clusters_seen++;
      if (got.pair_kind === 1'b1) pairs_seen++;
      if (expected_clusters.size() == 0) begin
         errors++;
         $display("%0t: cluster word with none expected, got %p", $time, got);
         return;
      end
      want = expected_clusters.pop_front();
      compare_field("pair_kind", want.pair_kind, got.pair_kind);
      compare_field("out_time", want.out_time, got.out_time);
      compare_field("out_charge", want.out_charge, got.out_charge);
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("out_z", want.out_z, got.out_z);
      compare_field("first_column", want.first_column, got.first_column);
      compare_field("first_cell", want.first_cell, got.first_cell);
      compare_field("second_column", want.second_column, got.second_column);
      compare_field("second_cell", want.second_cell, got.second_cell);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
   endtask

   // result side: sample at the edge, then pick the next ready
   initial begin : cluster_monitor
      int stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_cluster();
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 12) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_cell(scan_cell_t c);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.hit_present  <= c.hit_present;
      req_chan.hit_time     <= c.hit_time;
      req_chan.hit_charge   <= c.hit_charge;
      req_chan.hit_x        <= c.hit_x;
      req_chan.hit_y        <= c.hit_y;
      req_chan.spread_x     <= c.spread_x;
      req_chan.spread_t     <= c.spread_t;
      req_chan.downstream   <= c.downstream;
      req_chan.column_id    <= c.column_id;
      req_chan.cell_id      <= c.cell_id;
      req_chan.end_of_group <= c.end_of_group;
      req_chan.valid        <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_clusters(c);
      cells_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_clusters.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called with the block idle and nothing held
   task automatic apply_settings(logic [7:0] nsx, logic [7:0] nst, logic [7:0] gap,
                                 logic [15:0] slope);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_N_SIGMA_X;
      csr_wr_data <= {8'd0, nsx};
      @(posedge clock);
      csr_index   <= CSR_N_SIGMA_T;
      csr_wr_data <= {8'd0, nst};
      @(posedge clock);
      csr_index   <= CSR_LAYER_GAP;
      csr_wr_data <= {8'd0, gap};
      @(posedge clock);
      csr_index   <= CSR_TIME_SLOPE;
      csr_wr_data <= slope;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg.n_sigma_x  = nsx;
      cfg.n_sigma_t  = nst;
      cfg.layer_gap  = gap;
      cfg.time_slope = slope;
      settings_run++;
   endtask

   function automatic scan_cell_t mk(bit hit, int t, int q, int x, int y, int sx, int st,
                                     bit down, int col, int cidx, bit eog);
      scan_cell_t c;
      c.hit_present  = hit;
      c.hit_time     = 20'(t);
      c.hit_charge   = 16'(q);
      c.hit_x        = 16'(x);
      c.hit_y        = 16'(y);
      c.spread_x     = 16'(sx);
      c.spread_t     = 16'(st);
      c.downstream   = down;
      c.column_id    = 3'(col);
      c.cell_id      = 5'(cidx);
      c.end_of_group = eog;
      return c;
   endfunction

   function automatic logic [15:0] pick_spread();
      case ($urandom_range(0, 15))
         0:       return 16'd0;
         1:       return 16'hffff;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(20, 3000));
      endcase
   endfunction

   function automatic scan_cell_t random_cell();
      scan_cell_t c;
      c.hit_present  = $urandom_range(0, 1);
      c.hit_time     = 20'($urandom);
      c.hit_charge   = 16'($urandom);
      c.hit_x        = 16'($urandom);
      c.hit_y        = 16'($urandom);
      c.spread_x     = 16'($urandom);
      c.spread_t     = 16'($urandom);
      c.downstream   = $urandom_range(0, 1);
      c.column_id    = 3'($urandom_range(0, 5));
      c.cell_id      = 5'($urandom_range(0, 31));
      c.end_of_group = ($urandom_range(0, 7) == 0);
      return c;
   endfunction

   function automatic scan_cell_t seed_cell();
      scan_cell_t c;
      c = random_cell();
      c.hit_present = 1'b1;
      if ($urandom_range(0, 3) != 0)
         c.hit_time = 20'(longint'($urandom_range(0, 120000)) - 60000);
      c.spread_x = pick_spread();
      c.spread_t = pick_spread();
      return c;
   endfunction

   // a hit placed close to the previous one, mostly inside the cuts
   function automatic scan_cell_t near_cell(scan_cell_t prev);
      scan_cell_t c;
      longint ht, off, dx, dt, dy;
      c = seed_cell();
      c.downstream = ($urandom_range(0, 5) == 0) ? prev.downstream : !prev.downstream;
      ht  = sx20(prev.hit_time);
      off = (ht * longint'(cfg.time_slope)) >>> 16;
      dx  = longint'($urandom_range(0, 8 * int'(prev.spread_x))) - 4 * longint'(prev.spread_x);
      dt  = longint'($urandom_range(0, 8 * int'(prev.spread_t))) - 4 * longint'(prev.spread_t);
      dy  = longint'($urandom_range(0, 400)) - 200;
      c.hit_x    = 16'(sx16(prev.hit_x) + dx);
      c.hit_y    = 16'(sx16(prev.hit_y) + dy);
      c.hit_time = 20'(c.downstream ? ht + off - dt : ht - off - dt);
      return c;
   endfunction

   // one column pair in scan order, closed by end of group
   task automatic send_group(int unsigned len);
      scan_cell_t  prev, c;
      logic [2:0]  base;
      int unsigned roll;
      base = 3'($urandom_range(0, 2) * 2);
      prev = seed_cell();
      for (int k = 0; k < len; k++) begin
         roll = $urandom_range(0, 19);
         if (k == 0 || roll < 2) begin
            c = seed_cell();
         end else if (roll < 4) begin
            c = random_cell();
            c.hit_present = 1'b0;
         end else begin
            c = near_cell(prev);
         end
         c.column_id    = base + c.downstream;
         c.cell_id      = 5'(k);
         c.end_of_group = (k == len - 1);
         send_cell(c);
         if (c.hit_present) prev = c;
      end
   endtask

   task automatic test_pairing_basics();
      // upstream/downstream pair, then the downstream cell reused with its next cell
      send_cell(mk(1, 1000, 200, 0, 0, 100, 100, 0, 0, 0, 0));
      send_cell(mk(1, 1008, 300, 50, 10, 100, 100, 1, 1, 0, 0));
      send_cell(mk(1, 1000, 400, 60, 20, 100, 100, 0, 0, 1, 0));
      send_cell(mk(1, 1000, 500, 5000, 0, 100, 100, 1, 1, 1, 1));
      // same layer: held cell first
      send_cell(mk(1, 0, 10, 0, 0, 100, 100, 0, 2, 3, 0));
      send_cell(mk(1, 0, 21, 10, 5, 100, 100, 0, 2, 4, 1));
      // lone hits flushed by empty positions, both layers
      send_cell(mk(1, -5000, 7, 100, 0, 100, 100, 1, 3, 4, 0));
      send_cell(mk(0, 0, 0, 0, 0, 0, 0, 0, 3, 5, 0));
      send_cell(mk(1, 2000, 7, 100, 0, 100, 100, 0, 4, 6, 0));
      send_cell(mk(0, 0, 0, 0, 0, 0, 0, 0, 4, 7, 1));
      // time cut fails
      send_cell(mk(1, 0, 1, 0, 0, 100, 100, 0, 0, 2, 0));
      send_cell(mk(1, 5000, 1, 0, 0, 100, 100, 1, 1, 2, 1));
      // paired cell dropped when its next position is empty
      send_cell(mk(1, 300, 9, 0, 0, 100, 100, 0, 2, 8, 0));
      send_cell(mk(1, 302, 9, 20, 0, 100, 100, 1, 3, 8, 0));
      send_cell(mk(0, 0, 0, 0, 0, 0, 0, 0, 2, 9, 1));
   endtask

   task automatic test_field_extremes();
      send_cell(mk(1, 524287, 65535, 32767, 32767, 65535, 65535, 0, 5, 31, 0));
      send_cell(mk(1, 524287, 65535, 32767, 32767, 65535, 65535, 1, 5, 30, 1));
      send_cell(mk(1, -524288, 0, -32768, -32768, 65535, 65535, 1, 4, 0, 0));
      send_cell(mk(1, -524287, 0, -32768, -32767, 0, 0, 0, 4, 1, 1));
      // zero spreads never pair
      send_cell(mk(1, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
      send_cell(mk(1, 0, 5, 0, 0, 0, 0, 1, 1, 0, 1));
      // widest x difference still inside a 3 sigma cut of the widest spread
      send_cell(mk(1, 0, 0, 32767, 0, 65535, 65535, 0, 2, 0, 0));
      send_cell(mk(1, 0, 1, -32768, 0, 0, 0, 1, 3, 0, 1));
      send_cell(mk(0, -1, 65535, -1, -1, 65535, 65535, 1, 5, 31, 1));
   endtask

   task automatic test_register_settings();
      int phase_start;
      for (int p = 0; p < 6; p++) begin
         wait_drained();
         case (p)
            0:       apply_settings(8'd0, 8'd0, 8'd0, 16'd0);
            1:       apply_settings(8'hff, 8'hff, 8'hff, 16'hffff);
            2:       apply_settings(8'd16, 8'd16, 8'd1, 16'd1);
            default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                    16'($urandom));
         endcase
         phase_start = cells_sent;
         while (cells_sent - phase_start < 115) send_group($urandom_range(2, 10));
      end
   endtask

   task automatic test_random_stream();
      int  quiet_mark;
      int  pressure_mark;
      bit  paused;
      wait_drained();
      apply_settings(N_SIGMA_X_RESET, N_SIGMA_T_RESET, LAYER_GAP_RESET, TIME_SLOPE_RESET);
      quiet_mark    = TOTAL_CELLS - 150;
      pressure_mark = (cells_sent + quiet_mark) / 2;
      paused        = 1'b0;
      while (cells_sent < TOTAL_CELLS) begin
         if (!paused && cells_sent >= pressure_mark) begin
            wait_drained();
            paused = 1'b1;
         end
         idle_on = (cells_sent < quiet_mark) && ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 4) == 0) send_cell(random_cell());
         else send_group($urandom_range(2, 10));
      end
      idle_on = 1'b0;
   endtask

   initial begin
      errors        = 0;
      cells_sent    = 0;
      clusters_seen = 0;
      pairs_seen    = 0;
      settings_run  = 0;
      idle_on       = 1'b1;
      cfg.n_sigma_x  = N_SIGMA_X_RESET;
      cfg.n_sigma_t  = N_SIGMA_T_RESET;
      cfg.layer_gap  = LAYER_GAP_RESET;
      cfg.time_slope = TIME_SLOPE_RESET;
      held_ok   = 1'b0;
      held_used = 1'b0;
      held      = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_N_SIGMA_X;
      csr_wr_data <= 16'd0;
      req_chan.valid        <= 1'b0;
      req_chan.hit_present  <= 1'b0;
      req_chan.hit_time     <= '0;
      req_chan.hit_charge   <= '0;
      req_chan.hit_x        <= '0;
      req_chan.hit_y        <= '0;
      req_chan.spread_x     <= '0;
      req_chan.spread_t     <= '0;
      req_chan.downstream   <= 1'b0;
      req_chan.column_id    <= '0;
      req_chan.cell_id      <= '0;
      req_chan.end_of_group <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_pairing_basics();
      test_field_extremes();
      test_register_settings();
      test_random_stream();

      wait_drained();
      $display("%0d cells sent, %0d clusters checked (%0d pairs) under %0d register settings,",
               cells_sent, clusters_seen, pairs_seen, settings_run + 1);
      $display("with random stalls on both channels and a drained pause mid-stream.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
